[hdl/sacl_pkg.sv]
// Shared types, constants and helpers for the set-associative LRU cache model.
`default_nettype none

package sacl_pkg;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_BITS    = 64;

   localparam int SET_CFG_W   = 3;
   localparam int OFF_CFG_W   = 6;
   localparam int WAYS_CFG_W  = 4;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int KIND_W      = 2;
   localparam int HITS_W      = 2;
   localparam int TOTAL_W     = 32;

   localparam logic [SET_CFG_W-1:0]  RST_SET_BITS    = 3'd4;
   localparam logic [OFF_CFG_W-1:0]  RST_OFFSET_BITS = 6'd4;
   localparam logic [WAYS_CFG_W-1:0] RST_WAYS        = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_BITS    = 2'd0,
      CSR_OFFSET_BITS = 2'd1,
      CSR_WAYS        = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_STORE  = 2'd1,
      KIND_MODIFY = 2'd2,
      KIND_FETCH  = 2'd3
   } kind_type;

   typedef struct packed {
      logic hit;
      logic evict;
   } lookup_status_type;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                  input logic [HITS_W-1:0] inc);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, v} + {{(TOTAL_W-HITS_W+1){1'b0}}, inc};
      return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/sacl_ifs.sv]
// Request and response channel interfaces of the cache model.
`default_nettype none

interface sacl_req_if
   import sacl_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, kind, address, input ready);
   modport sink   (input valid, kind, address, output ready);
endinterface

interface sacl_rsp_if
   import sacl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [HITS_W-1:0]  hits_now;
   logic               misses_now;
   logic               evicted_now;
   logic [TOTAL_W-1:0] total_hits;
   logic [TOTAL_W-1:0] total_misses;
   logic [TOTAL_W-1:0] total_evictions;

   modport source (output valid, hits_now, misses_now, evicted_now, total_hits,
                   total_misses, total_evictions, input ready);
   modport sink   (input valid, hits_now, misses_now, evicted_now, total_hits,
                   total_misses, total_evictions, output ready);
endinterface

`default_nettype wire

[hdl/set_assoc_lru_cache_model_core.sv]
// Top level of the set-associative LRU cache model: config, pipeline and totals.
// Throughput: one request beat per cycle while the response side is not stalled, also
// back to back into the same set. The set row is read at the accepting edge; the
// lookup and write-back finish when the beat moves on into the response register.
// Reset: config returns to defaults, totals clear, per-set init flags clear; no
// clearing pass, requests are taken in the first cycle after reset.
`default_nettype none

module set_assoc_lru_cache_model_core
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   sacl_req_if.sink                    req_bus,
   sacl_rsp_if.source                  rsp_bus
);

   localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
   localparam int SH_W      = OFF_CFG_W + 1;

   logic [SET_CFG_W-1:0]  cfg_set_ff;
   logic [OFF_CFG_W-1:0]  cfg_off_ff;
   logic [WAYS_CFG_W-1:0] cfg_ways_ff;

   logic [SB_W-1:0]         set_bits_eff;
   logic [WAY_CNT_W-1:0]    ways_eff;
   logic [MAX_SET_BITS-1:0] set_mask;
   logic [ADDR_BITS-1:0]    addr_shift;
   logic [SH_W-1:0]         tag_shamt;
   logic [MAX_SET_BITS-1:0] req_set;
   logic [ADDR_BITS-1:0]    req_tag;
   logic                    req_take;

   logic                    s1_vld_ff;
   logic                    s1_vld_in;
   logic [KIND_W-1:0]       s1_kind_ff;
   logic [MAX_SET_BITS-1:0] s1_set_ff;
   logic [ADDR_BITS-1:0]    s1_tag_ff;
   logic                    s1_adv;
   logic                    s1_access;
   logic                    s1_modify;

   logic [MAX_WAYS-1:0]                rd_vld;
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_tag;
   logic [MAX_WAYS-1:0][RANK_W-1:0]    rd_rank;
   logic [MAX_WAYS-1:0]                wr_vld;
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] wr_tag;
   logic [MAX_WAYS-1:0][RANK_W-1:0]    wr_rank;
   logic                               wr_en;
   lookup_status_type                  status;

   logic [HITS_W-1:0]  hits_in;
   logic               misses_in;
   logic               evicted_in;
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   logic [HITS_W-1:0]  rsp_hits_ff;
   logic               rsp_misses_ff;
   logic               rsp_evicted_ff;
   logic [TOTAL_W-1:0] tot_hits_ff;
   logic [TOTAL_W-1:0] tot_misses_ff;
   logic [TOTAL_W-1:0] tot_evict_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_set_ff  <= RST_SET_BITS;
         cfg_off_ff  <= RST_OFFSET_BITS;
         cfg_ways_ff <= RST_WAYS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:    cfg_set_ff  <= csr_wdata[SET_CFG_W-1:0];
            CSR_OFFSET_BITS: cfg_off_ff  <= csr_wdata[OFF_CFG_W-1:0];
            CSR_WAYS:        cfg_ways_ff <= csr_wdata[WAYS_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      set_bits_eff = (cfg_set_ff > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(cfg_set_ff);
      if (cfg_ways_ff == '0) begin
         ways_eff = WAY_CNT_W'(1);
      end else if (cfg_ways_ff > MAX_WAYS) begin
         ways_eff = WAY_CNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CNT_W'(cfg_ways_ff);
      end
   end

   // address split; shifts past the word give zero
   assign addr_shift = req_bus.address >> cfg_off_ff;
   assign set_mask   = ~({MAX_SET_BITS{1'b1}} << set_bits_eff);
   assign req_set    = addr_shift[MAX_SET_BITS-1:0] & set_mask;
   assign tag_shamt  = SH_W'(cfg_off_ff) + SH_W'(set_bits_eff);
   assign req_tag    = req_bus.address >> tag_shamt;

   // handshake
   assign s1_adv        = s1_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_vld_ff || s1_adv;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_vld_in     = req_take || (s1_vld_ff && !s1_adv);
   assign rsp_vld_in    = s1_adv || (rsp_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= req_bus.kind;
         s1_set_ff  <= req_set;
         s1_tag_ff  <= req_tag;
      end
   end

   assign s1_access = s1_kind_ff != KIND_FETCH;
   assign s1_modify = s1_kind_ff == KIND_MODIFY;
   assign wr_en     = s1_adv && s1_access;

   sacl_array #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_array (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_set  (req_set),
      .rd_vld  (rd_vld),
      .rd_tag  (rd_tag),
      .rd_rank (rd_rank),
      .wr_en   (wr_en),
      .wr_set  (s1_set_ff),
      .wr_vld  (wr_vld),
      .wr_tag  (wr_tag),
      .wr_rank (wr_rank)
   );

   sacl_lookup #(
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_lookup (
      .ways_eff (ways_eff),
      .tag      (s1_tag_ff),
      .old_vld  (rd_vld),
      .old_tag  (rd_tag),
      .old_rank (rd_rank),
      .new_vld  (wr_vld),
      .new_tag  (wr_tag),
      .new_rank (wr_rank),
      .status   (status)
   );

   // second access of a modify always hits and leaves the row unchanged
   always_comb begin
      hits_in    = '0;
      misses_in  = 1'b0;
      evicted_in = 1'b0;
      if (s1_access) begin
         if (status.hit) begin
            hits_in = s1_modify ? HITS_W'(2) : HITS_W'(1);
         end else begin
            hits_in    = s1_modify ? HITS_W'(1) : HITS_W'(0);
            misses_in  = 1'b1;
            evicted_in = status.evict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_hits_ff   <= '0;
         tot_misses_ff <= '0;
         tot_evict_ff  <= '0;
      end else if (s1_adv) begin
         tot_hits_ff   <= sat_add(tot_hits_ff, hits_in);
         tot_misses_ff <= sat_add(tot_misses_ff, {1'b0, misses_in});
         tot_evict_ff  <= sat_add(tot_evict_ff, {1'b0, evicted_in});
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_hits_ff    <= hits_in;
         rsp_misses_ff  <= misses_in;
         rsp_evicted_ff <= evicted_in;
      end
   end

   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.hits_now        = rsp_hits_ff;
   assign rsp_bus.misses_now      = rsp_misses_ff;
   assign rsp_bus.evicted_now     = rsp_evicted_ff;
   assign rsp_bus.total_hits      = tot_hits_ff;
   assign rsp_bus.total_misses    = tot_misses_ff;
   assign rsp_bus.total_evictions = tot_evict_ff;

   a_evict_needs_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (!rsp_evicted_ff || rsp_misses_ff))
      else $error("eviction reported without a miss");

   a_hit_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_misses_ff && (rsp_hits_ff == 2'd0 || rsp_hits_ff == 2'd1))
                      || (!rsp_misses_ff && rsp_hits_ff != 2'd3)))
      else $error("hit and miss counts of one beat inconsistent");

   a_totals_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((tot_hits_ff >= $past(tot_hits_ff))
                         && (tot_misses_ff >= $past(tot_misses_ff))
                         && (tot_evict_ff >= $past(tot_evict_ff))))
      else $error("running total decreased");

endmodule

`default_nettype wire

[hdl/sacl_array.sv]
// Set memory: one row per set with valid, tag and age rank of every way.
`default_nettype none

module sacl_array
   import sacl_pkg::*;
#(
   parameter  int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter  int MAX_WAYS     = DEF_MAX_WAYS,
   parameter  int ADDR_BITS    = DEF_ADDR_BITS,
   localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   rd_en,
   input  wire logic [MAX_SET_BITS-1:0]                rd_set,
   output      logic [MAX_WAYS-1:0]                    rd_vld,
   output      logic [MAX_WAYS-1:0][ADDR_BITS-1:0]     rd_tag,
   output      logic [MAX_WAYS-1:0][RANK_W-1:0]        rd_rank,
   input  wire logic                                   wr_en,
   input  wire logic [MAX_SET_BITS-1:0]                wr_set,
   input  wire logic [MAX_WAYS-1:0]                    wr_vld,
   input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0]     wr_tag,
   input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]        wr_rank
);

   localparam int SETS   = 2 ** MAX_SET_BITS;

   typedef struct packed {
      logic [MAX_WAYS-1:0]                vld;
      logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
      logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
   } row_type;

   row_type             mem [SETS];
   row_type             rd_row_ff;
   row_type             wr_row;
   logic [SETS-1:0]     row_init_ff;
   logic [SETS-1:0]     row_init_in;

   assign wr_row = '{vld: wr_vld, tag: wr_tag, rank: wr_rank};

   always_comb begin
      row_init_in = row_init_ff;
      if (wr_en) begin
         row_init_in[wr_set] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
      end else begin
         row_init_ff <= row_init_in;
      end
   end

   // a row never written reads as all zero; same-edge write is bypassed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_set] <= wr_row;
      end
      if (rd_en) begin
         if (wr_en && (wr_set == rd_set)) begin
            rd_row_ff <= wr_row;
         end else if (!row_init_ff[rd_set]) begin
            rd_row_ff <= '0;
         end else begin
            rd_row_ff <= mem[rd_set];
         end
      end
   end

   assign rd_vld  = rd_row_ff.vld;
   assign rd_tag  = rd_row_ff.tag;
   assign rd_rank = rd_row_ff.rank;

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> row_init_ff[$past(wr_set)])
      else $error("written row not marked initialized");

   a_fwd_newest: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && (rd_set == wr_set)) |=> (rd_vld == $past(wr_vld)))
      else $error("read of a row written at the same edge missed the new data");

endmodule

`default_nettype wire

[hdl/sacl_lookup.sv]
// Tag compare, victim choice and LRU rank update for one set row.
`default_nettype none

module sacl_lookup
   import sacl_pkg::*;
#(
   parameter  int MAX_WAYS  = DEF_MAX_WAYS,
   parameter  int ADDR_BITS = DEF_ADDR_BITS,
   localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1)
) (
   input  wire logic [WAY_CNT_W-1:0]               ways_eff,
   input  wire logic [ADDR_BITS-1:0]               tag,
   input  wire logic [MAX_WAYS-1:0]                old_vld,
   input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0] old_tag,
   input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]    old_rank,
   output      logic [MAX_WAYS-1:0]                new_vld,
   output      logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tag,
   output      logic [MAX_WAYS-1:0][RANK_W-1:0]    new_rank,
   output      lookup_status_type                  status
);

   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] use_vec;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] inv_vec;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         use_vec[i] = WAY_CNT_W'(i) < ways_eff;
         hit_vec[i] = use_vec[i] && old_vld[i] && (old_tag[i] == tag);
         inv_vec[i] = use_vec[i] && !old_vld[i];
      end
   end

   always_comb begin
      logic [WAY_W-1:0]  hit_way;
      logic [RANK_W-1:0] hit_rank;
      logic [WAY_W-1:0]  inv_way;
      logic [WAY_W-1:0]  lru_way;
      logic [RANK_W-1:0] lru_rank;
      logic [WAY_W-1:0]  victim;
      logic              hit;
      logic              inv_found;

      hit_way  = '0;
      inv_way  = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WAY_W'(i);
         end
         if (inv_vec[i]) begin
            inv_way = WAY_W'(i);
         end
      end
      hit       = |hit_vec;
      inv_found = |inv_vec;
      hit_rank  = old_rank[hit_way];

      // oldest in-use way, ties to the lowest index
      lru_way  = '0;
      lru_rank = old_rank[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (use_vec[i] && (old_rank[i] > lru_rank)) begin
            lru_way  = WAY_W'(i);
            lru_rank = old_rank[i];
         end
      end

      new_vld  = old_vld;
      new_tag  = old_tag;
      new_rank = old_rank;
      victim   = inv_found ? inv_way : lru_way;

      if (hit) begin
         for (int k = 0; k < MAX_WAYS; k++) begin
            if ((WAY_W'(k) != hit_way) && use_vec[k] && old_vld[k]
                && (old_rank[k] < hit_rank)) begin
               new_rank[k] = old_rank[k] + RANK_W'(1);
            end
         end
         new_rank[hit_way] = '0;
      end else begin
         for (int k = 0; k < MAX_WAYS; k++) begin
            if (inv_found) begin
               if (use_vec[k] && old_vld[k] && (old_rank[k] < RANK_MAX)) begin
                  new_rank[k] = old_rank[k] + RANK_W'(1);
               end
            end else if ((WAY_W'(k) != lru_way) && use_vec[k]
                         && (old_rank[k] < lru_rank)) begin
               new_rank[k] = old_rank[k] + RANK_W'(1);
            end
         end
         new_vld[victim]  = 1'b1;
         new_tag[victim]  = tag;
         new_rank[victim] = '0;
      end

      status.hit   = hit;
      status.evict = !hit && !inv_found;
   end

endmodule

`default_nettype wire

[dv/tb_set_assoc_lru_cache_model_core.sv]
// Self-checking testbench for the set-associative LRU cache model core.
`default_nettype none

module tb_set_assoc_lru_cache_model_core;
   import sacl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SETS    = 1 << DEF_MAX_SET_BITS;
   localparam int NUM_LINES   = NUM_SETS * DEF_MAX_WAYS;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 3000;
   localparam int PHASES      = 10;
   localparam int PHASE_BEATS = 105;

   typedef struct packed {
      logic [HITS_W-1:0]  hits_now;
      logic               misses_now;
      logic               evicted_now;
      logic [TOTAL_W-1:0] total_hits;
      logic [TOTAL_W-1:0] total_misses;
      logic [TOTAL_W-1:0] total_evictions;
   } access_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   csr_index_type             csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   sacl_req_if #(.ADDR_BITS(DEF_ADDR_BITS)) req_bus ();
   sacl_rsp_if                              rsp_bus ();

   set_assoc_lru_cache_model_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // cache shadow: tags, valid bits, LRU ranks, totals and register copies
   bit                 line_valid_q [NUM_LINES];
   logic [63:0]        line_tag_q   [NUM_LINES];
   int                 line_rank_q  [NUM_LINES];
   logic [TOTAL_W-1:0] hit_tally, miss_tally, evict_tally;
   logic [SET_CFG_W-1:0]  cfg_set_bits;
   logic [OFF_CFG_W-1:0]  cfg_offset_bits;
   logic [WAYS_CFG_W-1:0] cfg_ways;

   access_result_type expected_results[$];

   int error_count, idle_cycles;
   int seen_hits, seen_misses, seen_evicts, settings_used;
   int kind_count[4];

   int  burst_left, stall_mode, mode_left, hold_left;
   bit  stream_mode, hold_pending;
   logic [1:0] stall_phase;

   function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // one lookup with LRU update; returns 1 on hit
   function automatic bit lookup_line(input logic [63:0] addr, output bit evicted);
      int s, boff, w, sh, set_idx, base, victim, i, k, r, vr;
      logic [63:0] tg;
      bit hit, found;
      s = (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
      boff = cfg_offset_bits;
      w = (cfg_ways == 0) ? 1 : ((cfg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cfg_ways));
      set_idx = (boff < 64) ? int'((addr >> boff) & ((64'd1 << s) - 64'd1)) : 0;
      sh = s + boff;
      tg = (sh < 64) ? (addr >> sh) : 64'd0;
      base = set_idx * DEF_MAX_WAYS;
      evicted = 1'b0;
      hit = 1'b0;
      found = 1'b0;
      victim = 0;
      for (i = 0; i < w && !hit; i++) begin
         if (line_valid_q[base+i] && line_tag_q[base+i] == tg) begin
            r = line_rank_q[base+i];
            for (k = 0; k < w; k++)
               if (k != i && line_valid_q[base+k] && line_rank_q[base+k] < r)
                  line_rank_q[base+k]++;
            line_rank_q[base+i] = 0;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         for (i = 0; i < w && !found; i++) begin
            if (!line_valid_q[base+i]) begin
               victim = i;
               found = 1'b1;
            end
         end
         if (found) begin
            for (i = 0; i < w; i++)
               if (line_valid_q[base+i] && line_rank_q[base+i] < DEF_MAX_WAYS - 1)
                  line_rank_q[base+i]++;
         end else begin
            for (i = 1; i < w; i++)
               if (line_rank_q[base+i] > line_rank_q[base+victim])
                  victim = i;
            vr = line_rank_q[base+victim];
            for (i = 0; i < w; i++)
               if (i != victim && line_rank_q[base+i] < vr)
                  line_rank_q[base+i]++;
            evicted = 1'b1;
         end
         line_valid_q[base+victim] = 1'b1;
         line_tag_q[base+victim] = tg;
         line_rank_q[base+victim] = 0;
      end
      return hit;
   endfunction

   function automatic access_result_type predict_access(input kind_type kind,
                                                        input logic [63:0] addr);
      access_result_type res;
      int n, j;
      bit hit, ev;
      res = '0;
      case (kind)
         KIND_LOAD, KIND_STORE: n = 1;
         KIND_MODIFY:           n = 2;
         default:               n = 0;
      endcase
      for (j = 0; j < n; j++) begin
         hit = lookup_line(addr, ev);
         if (hit) begin
            res.hits_now++;
            hit_tally = bump_total(hit_tally);
         end else begin
            res.misses_now = 1'b1;
            miss_tally = bump_total(miss_tally);
         end
         if (ev) begin
            res.evicted_now = 1'b1;
            evict_tally = bump_total(evict_tally);
         end
      end
      res.total_hits = hit_tally;
      res.total_misses = miss_tally;
      res.total_evictions = evict_tally;
      return res;
   endfunction

   // response check first, then prediction of the request beat taken at this edge
   always @(posedge clock) begin : monitor
      access_result_type got, want;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            line_valid_q[i] = 1'b0;
            line_tag_q[i] = '0;
            line_rank_q[i] = 0;
         end
         hit_tally = '0;
         miss_tally = '0;
         evict_tally = '0;
         cfg_set_bits = RST_SET_BITS;
         cfg_offset_bits = RST_OFFSET_BITS;
         cfg_ways = RST_WAYS;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            idle_cycles = 0;
            got.hits_now = rsp_bus.hits_now;
            got.misses_now = rsp_bus.misses_now;
            got.evicted_now = rsp_bus.evicted_now;
            got.total_hits = rsp_bus.total_hits;
            got.total_misses = rsp_bus.total_misses;
            got.total_evictions = rsp_bus.total_evictions;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: response beat with none expected");
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: exp %0d/%0d/%0d %0d/%0d/%0d got %0d/%0d/%0d %0d/%0d/%0d",
                        want.hits_now, want.misses_now, want.evicted_now, want.total_hits,
                        want.total_misses, want.total_evictions, got.hits_now,
                        got.misses_now, got.evicted_now, got.total_hits,
                        got.total_misses, got.total_evictions);
               end
               seen_hits += got.hits_now;
               seen_misses += got.misses_now;
               seen_evicts += got.evicted_now;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            idle_cycles = 0;
            kind_count[req_bus.kind]++;
            expected_results.push_back(
               predict_access(kind_type'(req_bus.kind), req_bus.address));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SET_BITS:    cfg_set_bits = csr_wdata[SET_CFG_W-1:0];
               CSR_OFFSET_BITS: cfg_offset_bits = csr_wdata[OFF_CFG_W-1:0];
               CSR_WAYS:        cfg_ways = csr_wdata[WAYS_CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin : rsp_stall
      if (reset) begin
         stall_phase <= '0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
         end else
            mode_left--;
         stall_phase <= stall_phase + 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 9) < 4);
               default: rsp_bus.ready <= (stall_phase != 2'd0);
            endcase
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("tb_set_assoc_lru_cache_model_core NOT OK");
      $finish;
   end

   task automatic send_beat(input kind_type kind, input logic [63:0] addr);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.address <= addr;
      do
         @(posedge clock);
      while (!req_bus.ready);
      if (burst_left > 0)
         burst_left--;
      else begin
         gap = ($urandom_range(0, 3) == 0 || stream_mode) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic configure_cache(input logic [CSR_DATA_W-1:0] set_val, off_val, ways_val);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_SET_BITS;
      csr_wdata <= set_val;
      @(posedge clock);
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= off_val;
      @(posedge clock);
      csr_index <= CSR_WAYS;
      csr_wdata <= ways_val;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [63:0] place_address(input logic [63:0] tg, input int set_idx,
                                                 input int s, input int boff);
      logic [63:0] a;
      a = {$urandom, $urandom} & ((64'd1 << boff) - 64'd1);
      a |= 64'(set_idx) << boff;
      if (s + boff < 64)
         a |= tg << (s + boff);
      return a;
   endfunction

   // reset register values, hit/miss/evict, modify, fetch, address extremes
   task automatic test_reset_defaults();
      send_beat(KIND_FETCH, 64'd0);
      send_beat(KIND_LOAD, 64'd0);
      send_beat(KIND_STORE, 64'd0);
      send_beat(KIND_MODIFY, 64'h100);
      send_beat(KIND_MODIFY, 64'h100);
      send_beat(KIND_LOAD, '1);
      send_beat(KIND_STORE, '1);
      send_beat(KIND_FETCH, '1);
   endtask

   // shrinking then growing the ways leaves two ways with one tag
   task automatic test_duplicate_tags();
      configure_cache(6'd4, 6'd4, 6'd2);
      send_beat(KIND_LOAD, 64'h100);
      send_beat(KIND_LOAD, 64'h200);
      configure_cache(6'd4, 6'd4, 6'd1);
      send_beat(KIND_LOAD, 64'h200);
      configure_cache(6'd4, 6'd4, 6'd2);
      send_beat(KIND_LOAD, 64'h208);
      send_beat(KIND_LOAD, 64'h300);
      send_beat(KIND_LOAD, 64'h200);
   endtask

   // saturating set bits and ways, zero ways, tag shifted out entirely
   task automatic test_config_extremes();
      configure_cache(6'h3F, 6'd0, 6'h30);
      send_beat(KIND_LOAD, 64'd0);
      send_beat(KIND_LOAD, 64'h3F);
      send_beat(KIND_STORE, 64'h40);
      configure_cache(6'd0, 6'd63, 6'd15);
      send_beat(KIND_LOAD, 64'h8000_0000_0000_0000);
      send_beat(KIND_LOAD, 64'd0);
      send_beat(KIND_MODIFY, 64'h4000_0000_0000_0000);
      configure_cache(6'd6, 6'd58, 6'd8);
      send_beat(KIND_LOAD, {$urandom, $urandom});
      send_beat(KIND_LOAD, {$urandom, $urandom});
      configure_cache(6'd6, 6'd32, 6'd8);
      send_beat(KIND_STORE, 64'hFFFF_FFFF_0000_0000);
   endtask

   task automatic run_traffic(input int s, boff, w, beats);
      logic [63:0] tag_pool[12];
      int set_pool[3];
      int ntags, nsets, done, pick;
      kind_type kind;
      logic [63:0] addr;
      ntags = w + $urandom_range(0, 3);
      nsets = $urandom_range(1, 3);
      for (int i = 0; i < ntags; i++)
         tag_pool[i] = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 15))
                                                   : {$urandom, $urandom};
      for (int i = 0; i < nsets; i++)
         set_pool[i] = $urandom_range(0, (1 << s) - 1);
      done = 0;
      while (done < beats) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 35) ? KIND_LOAD : (pick < 60) ? KIND_STORE :
                (pick < 88) ? KIND_MODIFY : KIND_FETCH;
         if ($urandom_range(0, 99) < 85)
            addr = place_address(tag_pool[$urandom_range(0, ntags - 1)],
                                 set_pool[$urandom_range(0, nsets - 1)], s, boff);
         else
            addr = {$urandom, $urandom};
         send_beat(kind, addr);
         if (kind != KIND_FETCH)
            done++;
      end
   endtask

   task automatic test_random_traffic();
      int sv, ov, wv, s, w;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin sv = 0; ov = 0;  wv = 1;  end
            1:       begin sv = 7; ov = 63; wv = 15; end
            2:       begin sv = 6; ov = 32; wv = 8;  end
            3:       begin sv = 2; ov = 60; wv = 0;  end
            4:       begin sv = 6; ov = 3;  wv = 8;  end
            default: begin
               sv = $urandom_range(0, 7);
               pick_offset(ov);
               wv = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
            end
         endcase
         configure_cache(6'(sv) | 6'($urandom_range(0, 7) << 3), 6'(ov),
                         6'(wv) | 6'($urandom_range(0, 3) << 4));
         s = (sv > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sv;
         w = (wv == 0) ? 1 : ((wv > DEF_MAX_WAYS) ? DEF_MAX_WAYS : wv);
         stream_mode = ($urandom_range(0, 3) == 0);
         run_traffic(s, ov, w, PHASE_BEATS);
         stream_mode = 1'b0;
      end
   endtask

   task automatic pick_offset(output int ov);
      int r;
      r = $urandom_range(0, 3);
      ov = (r < 2) ? $urandom_range(0, 12) : (r == 2) ? $urandom_range(13, 40)
                                                   : $urandom_range(41, 63);
   endtask

   // receiver holds off while the sender streams, so the input stalls
   task automatic test_output_stall();
      configure_cache(6'd3, 6'd5, 6'd4);
      hold_pending = 1'b1;
      stream_mode = 1'b1;
      run_traffic(3, 5, 4, 48);
      stream_mode = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SET_BITS;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_LOAD;
      req_bus.address = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_duplicate_tags();
      test_config_extremes();
      test_output_stall();
      test_random_traffic();

      wait_idle();
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         error_count++;
         $display("ERROR: %0d responses never arrived", expected_results.size());
      end
      $display("Covered %0d loads, %0d stores, %0d modifies, %0d fetches, %0d settings",
               kind_count[KIND_LOAD], kind_count[KIND_STORE], kind_count[KIND_MODIFY],
               kind_count[KIND_FETCH], settings_used);
      $display("Responses showed %0d hits, %0d misses, %0d evictions; %0d mismatches",
               seen_hits, seen_misses, seen_evicts, error_count);
      if (error_count == 0)
         $display("tb_set_assoc_lru_cache_model_core OK");
      else
         $display("tb_set_assoc_lru_cache_model_core NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

[set_assoc_lru_cache_model_core.f]
hdl/sacl_pkg.sv
hdl/sacl_ifs.sv
hdl/sacl_array.sv
hdl/sacl_lookup.sv
hdl/set_assoc_lru_cache_model_core.sv
dv/tb_set_assoc_lru_cache_model_core.sv
